>>> hw/rtl/e2q_pkg.sv
// ----------------------------------------------------------------------------
// e2q_pkg
// Constants and types shared by the Euler to quaternion pipeline.
// ----------------------------------------------------------------------------
package e2q_pkg;
	localparam int STEPS = 28;
	localparam int CW = 34;
	localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

	typedef logic signed [CW-1:0] cval_t;
	typedef logic signed [21:0] q20_t;

	function automatic cval_t atan_phase(input int i);
		cval_t r;
		case (i)
			0: r = 34'sd536870912;
			1: r = 34'sd316933406;
			2: r = 34'sd167458907;
			3: r = 34'sd85004756;
			4: r = 34'sd42667331;
			5: r = 34'sd21354465;
			6: r = 34'sd10679838;
			7: r = 34'sd5340245;
			8: r = 34'sd2670163;
			9: r = 34'sd1335087;
			10: r = 34'sd667544;
			11: r = 34'sd333772;
			12: r = 34'sd166886;
			13: r = 34'sd83443;
			14: r = 34'sd41722;
			15: r = 34'sd20861;
			16: r = 34'sd10430;
			17: r = 34'sd5215;
			18: r = 34'sd2608;
			19: r = 34'sd1304;
			20: r = 34'sd652;
			21: r = 34'sd326;
			22: r = 34'sd163;
			23: r = 34'sd81;
			24: r = 34'sd41;
			25: r = 34'sd20;
			26: r = 34'sd10;
			27: r = 34'sd5;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage

>>> hw/rtl/euler_to_quaternion.sv
// Throughput: one item per cycle while not stalled; 28 CORDIC stages + rounding + 4 combine stages.
// Whole pipeline advances when the output slot is empty or being taken.
// Reset clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Z-Y-X Euler angles to unit quaternion, Q2.15 components.
// ----------------------------------------------------------------------------
module euler_to_quaternion #(
	parameter int ANGLE_BITS = 16,
	parameter int FRAC_BITS = 15
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [ANGLE_BITS-1:0] roll_angle,
	input  logic signed [ANGLE_BITS-1:0] pitch_angle,
	input  logic signed [ANGLE_BITS-1:0] yaw_angle,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [FRAC_BITS+1:0]  quat_w,
	output logic signed [FRAC_BITS+1:0]  quat_x,
	output logic signed [FRAC_BITS+1:0]  quat_y,
	output logic signed [FRAC_BITS+1:0]  quat_z
);
	localparam int LAT = e2q_pkg::STEPS + 5;
	logic [LAT-1:0] vld_q;
	logic en;
	e2q_pkg::q20_t cr, sr, cp, sp, cy, sy;

	assign en = !vld_q[LAT-1] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], in_valid};
	end

	e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
		.clk(clk), .en(en), .angle(roll_angle), .cos_v(cr), .sin_v(sr));
	e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
		.clk(clk), .en(en), .angle(pitch_angle), .cos_v(cp), .sin_v(sp));
	e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
		.clk(clk), .en(en), .angle(yaw_angle), .cos_v(cy), .sin_v(sy));

	e2q_combine #(.FRAC_BITS(FRAC_BITS)) u_comb (
		.clk(clk), .en(en), .cr(cr), .sr(sr), .cp(cp), .sp(sp), .cy(cy), .sy(sy),
		.qw(quat_w), .qx(quat_x), .qy(quat_y), .qz(quat_z));
endmodule

>>> hw/rtl/e2q_cordic.sv
// ----------------------------------------------------------------------------
// e2q_cordic
// Pipelined rotation CORDIC: sine and cosine of half an angle, Q20.
// One micro-rotation per stage, 28 stages plus a rounding stage.
// ----------------------------------------------------------------------------
module e2q_cordic #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [ANGLE_BITS-1:0] angle,
	output e2q_pkg::q20_t                cos_v,
	output e2q_pkg::q20_t                sin_v
);
	localparam int N = e2q_pkg::STEPS;
	e2q_pkg::cval_t xr, yr;

	for (genvar i = 0; i < N; i++) begin : g_st
		e2q_pkg::cval_t x_in, y_in, z_in;
		e2q_pkg::cval_t x_s, y_s, z_s;

		if (i == 0) begin : g_first
			assign x_in = e2q_pkg::GAIN_Q30;
			assign y_in = '0;
			assign z_in = e2q_pkg::cval_t'(angle) <<< (31 - ANGLE_BITS);
		end else begin : g_next
			assign x_in = g_st[i-1].x_s;
			assign y_in = g_st[i-1].y_s;
			assign z_in = g_st[i-1].z_s;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_in[e2q_pkg::CW-1]) begin
					x_s <= x_in - (y_in >>> i);
					y_s <= y_in + (x_in >>> i);
					z_s <= z_in - e2q_pkg::atan_phase(i);
				end else begin
					x_s <= x_in + (y_in >>> i);
					y_s <= y_in - (x_in >>> i);
					z_s <= z_in + e2q_pkg::atan_phase(i);
				end
			end
		end
	end

	assign xr = (g_st[N-1].x_s + e2q_pkg::cval_t'(512)) >>> 10;
	assign yr = (g_st[N-1].y_s + e2q_pkg::cval_t'(512)) >>> 10;

	always_ff @(posedge clk) begin
		if (en) begin
			cos_v <= xr[21:0];
			sin_v <= yr[21:0];
		end
	end
endmodule

>>> hw/rtl/e2q_combine.sv
// ----------------------------------------------------------------------------
// e2q_combine
// Triple products, sums, rounding and clamp. Four register stages.
// ----------------------------------------------------------------------------
module e2q_combine #(
	parameter int FRAC_BITS = 15
) (
	input  logic                          clk,
	input  logic                          en,
	input  e2q_pkg::q20_t                 cr, sr, cp, sp, cy, sy,
	output logic signed [FRAC_BITS+1:0]   qw, qx, qy, qz
);
	typedef logic signed [43:0] p2_t;
	typedef logic signed [44:0] pp_t;
	typedef logic signed [65:0] p3_t;
	localparam int SH = 60 - FRAC_BITS;

	p2_t cc_s1, sc_s1, cs_s1, ss_s1;
	e2q_pkg::q20_t cy_s1, sy_s1;
	pp_t hi_s2 [0:7];
	pp_t lo_s2 [0:7];
	p3_t a_s3 [0:3];
	logic signed [FRAC_BITS+1:0] q_s4 [0:3];

	// upper 22 bits of a pair product times a third factor
	function automatic pp_t mul_hi(input p2_t a, input e2q_pkg::q20_t b);
		logic signed [21:0] h;
		h = a[43:22];
		return pp_t'(h) * pp_t'(b);
	endfunction

	// lower 22 bits, taken as unsigned
	function automatic pp_t mul_lo(input p2_t a, input e2q_pkg::q20_t b);
		logic signed [22:0] l;
		l = {1'b0, a[21:0]};
		return pp_t'(l) * pp_t'(b);
	endfunction

	function automatic p3_t merge_pp(input pp_t h, input pp_t l);
		return (p3_t'(h) <<< 22) + p3_t'(l);
	endfunction

	function automatic logic signed [FRAC_BITS+1:0] round_clamp(input p3_t a);
		p3_t r;
		p3_t one;
		one = p3_t'(1) <<< FRAC_BITS;
		r = (a + (p3_t'(1) <<< (SH - 1))) >>> SH;
		if (r > one) return one[FRAC_BITS+1:0];
		if (r < -one) return -one[FRAC_BITS+1:0];
		return r[FRAC_BITS+1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			cc_s1 <= p2_t'(cr) * p2_t'(cp);
			sc_s1 <= p2_t'(sr) * p2_t'(cp);
			cs_s1 <= p2_t'(cr) * p2_t'(sp);
			ss_s1 <= p2_t'(sr) * p2_t'(sp);
			cy_s1 <= cy;
			sy_s1 <= sy;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hi_s2[0] <= mul_hi(cc_s1, cy_s1);
			lo_s2[0] <= mul_lo(cc_s1, cy_s1);
			hi_s2[1] <= mul_hi(ss_s1, sy_s1);
			lo_s2[1] <= mul_lo(ss_s1, sy_s1);
			hi_s2[2] <= mul_hi(sc_s1, cy_s1);
			lo_s2[2] <= mul_lo(sc_s1, cy_s1);
			hi_s2[3] <= mul_hi(cs_s1, sy_s1);
			lo_s2[3] <= mul_lo(cs_s1, sy_s1);
			hi_s2[4] <= mul_hi(cs_s1, cy_s1);
			lo_s2[4] <= mul_lo(cs_s1, cy_s1);
			hi_s2[5] <= mul_hi(sc_s1, sy_s1);
			lo_s2[5] <= mul_lo(sc_s1, sy_s1);
			hi_s2[6] <= mul_hi(cc_s1, sy_s1);
			lo_s2[6] <= mul_lo(cc_s1, sy_s1);
			hi_s2[7] <= mul_hi(ss_s1, cy_s1);
			lo_s2[7] <= mul_lo(ss_s1, cy_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3[0] <= merge_pp(hi_s2[0], lo_s2[0]) + merge_pp(hi_s2[1], lo_s2[1]);
			a_s3[1] <= merge_pp(hi_s2[2], lo_s2[2]) - merge_pp(hi_s2[3], lo_s2[3]);
			a_s3[2] <= merge_pp(hi_s2[4], lo_s2[4]) + merge_pp(hi_s2[5], lo_s2[5]);
			a_s3[3] <= merge_pp(hi_s2[6], lo_s2[6]) - merge_pp(hi_s2[7], lo_s2[7]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s4[0] <= round_clamp(a_s3[0]);
			q_s4[1] <= round_clamp(a_s3[1]);
			q_s4[2] <= round_clamp(a_s3[2]);
			q_s4[3] <= round_clamp(a_s3[3]);
		end
	end

	assign qw = q_s4[0];
	assign qx = q_s4[1];
	assign qy = q_s4[2];
	assign qz = q_s4[3];
endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks euler_to_quaternion against a bit-exact CORDIC and triple-product
// predictor: directed angle corners first, then random attitudes with bursty
// input traffic and output back-pressure.
// ----------------------------------------------------------------------------
module testbench;
	localparam int N_RANDOM = 900;
	localparam int LIMIT = 200000;

	typedef struct {
		logic signed [16:0] w, x, y, z;
	} quat_t;

	typedef struct {
		logic signed [15:0] roll, pitch, yaw;
		bit typed;
		quat_t q;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [15:0] roll_angle = '0, pitch_angle = '0, yaw_angle = '0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [16:0] quat_w, quat_x, quat_y, quat_z;

	bit typed_now = 0;
	quat_t typed_q;
	quat_t quat_queue[$];
	bit took = 0;
	int cycles = 0, n_bad = 0, n_in = 0, n_out = 0;

	longint atan_tab[28] = '{536870912, 316933406, 167458907, 85004756, 42667331,
		21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5};

	euler_to_quaternion DUT (.*);

	always #1 clk = ~clk;

	function automatic void half_sincos(input logic signed [15:0] a,
			output longint c, output longint s);
		longint z, x, y, dx, dy;
		z = longint'(a) * (64'sd1 <<< 15);
		x = 652032874;
		y = 0;
		for (int i = 0; i < 28; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_tab[i];
			end else begin
				x += dx; y -= dy; z += atan_tab[i];
			end
		end
		c = (x + 512) >>> 10;
		s = (y + 512) >>> 10;
	endfunction

	function automatic logic signed [16:0] to_q15(input longint q60);
		longint v;
		v = (q60 + (64'sd1 <<< 44)) >>> 45;
		if (v > 32768) v = 32768;
		if (v < -32768) v = -32768;
		return v[16:0];
	endfunction

	function automatic quat_t rotation_quat(input logic signed [15:0] r, p, yw);
		longint cr, sr, cp, sp, cy, sy;
		quat_t q;
		half_sincos(r, cr, sr);
		half_sincos(p, cp, sp);
		half_sincos(yw, cy, sy);
		q.w = to_q15(cr * cp * cy + sr * sp * sy);
		q.x = to_q15(sr * cp * cy - cr * sp * sy);
		q.y = to_q15(cr * sp * cy + sr * cp * sy);
		q.z = to_q15(cr * cp * sy - sr * sp * cy);
		return q;
	endfunction

	always @(posedge clk) begin
		quat_t e;
		cycles <= cycles + 1;
		took <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			n_in <= n_in + 1;
			if (typed_now)
				quat_queue.insert(quat_queue.size(), typed_q);
			else
				quat_queue.insert(quat_queue.size(),
					rotation_quat(roll_angle, pitch_angle, yaw_angle));
		end
		if (out_valid && out_ready) begin
			n_out <= n_out + 1;
			if (quat_queue.size() == 0) begin
				n_bad++;
				if (n_bad <= 10) $display("unexpected item w=%0d x=%0d y=%0d z=%0d",
					quat_w, quat_x, quat_y, quat_z);
			end else begin
				e = quat_queue.pop_front();
				if (e.w !== quat_w || e.x !== quat_x || e.y !== quat_y || e.z !== quat_z) begin
					n_bad++;
					if (n_bad <= 10)
						$display("mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
							e.w, e.x, e.y, e.z, quat_w, quat_x, quat_y, quat_z);
				end
			end
		end
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("** euler_to_quaternion: FAILED **");
			$finish;
		end
	end

	// receiver stall pattern: four modes in turn, chosen from the cycle counter
	always @(negedge clk) begin
		case ((cycles / 64) % 4)
			0: out_ready <= 1;
			1: out_ready <= ($urandom_range(0, 9) < 7);
			2: out_ready <= (cycles % 5 != 0);
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	task automatic send(input row_t r);
		roll_angle <= r.roll;
		pitch_angle <= r.pitch;
		yaw_angle <= r.yaw;
		typed_now <= r.typed;
		typed_q <= r.q;
		in_valid <= 1;
		do @(negedge clk); while (!took);
	endtask

	task automatic gap(input int n);
		if (n > 0) begin
			in_valid <= 0;
			repeat (n) @(negedge clk);
		end
	endtask

	row_t dir[$];
	row_t r;
	int burst;
	logic signed [15:0] corners[7] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh4000,
		16'shc000, 16'sh0001, 16'shffff};

	initial begin
		r = '{16'sh0000, 16'sh0000, 16'sh0000, 1, '{17'sd32768, 0, 0, 0}};
		dir.insert(dir.size(), r);
		r = '{16'sh8000, 16'sh0000, 16'sh0000, 1, '{0, -17'sd32768, 0, 0}};
		dir.insert(dir.size(), r);
		r = '{16'sh0000, 16'sh8000, 16'sh0000, 1, '{0, 0, -17'sd32768, 0}};
		dir.insert(dir.size(), r);
		r = '{16'sh0000, 16'sh0000, 16'sh8000, 1, '{0, 0, 0, -17'sd32768}};
		dir.insert(dir.size(), r);
		for (int i = 0; i < 7; i++) begin
			r = '{corners[i], corners[(i + 2) % 7], corners[(i + 4) % 7], 0, '{0, 0, 0, 0}};
			dir.insert(dir.size(), r);
			r = '{corners[i], corners[i], corners[i], 0, '{0, 0, 0, 0}};
			dir.insert(dir.size(), r);
		end
		r = '{16'sh7fff, 16'sh8000, 16'sh7fff, 0, '{0, 0, 0, 0}};
		dir.insert(dir.size(), r);
		r = '{16'sh5555, 16'shaaaa, 16'sh2000, 0, '{0, 0, 0, 0}};
		dir.insert(dir.size(), r);

		repeat (12) @(negedge clk);
		arst_n <= 1;
		repeat (2) @(negedge clk);

		foreach (dir[i]) begin
			send(dir[i]);
			if (i % 5 == 4) gap($urandom_range(1, 4));
		end

		burst = 0;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (burst == 0) begin
				gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 12));
				burst = $urandom_range(1, 40);
			end
			burst--;
			if (i == N_RANDOM / 2) begin
				in_valid <= 0;
				while (quat_queue.size() != 0) @(negedge clk);
			end
			r.typed = 0;
			r.roll = 16'($urandom);
			r.pitch = 16'($urandom);
			r.yaw = 16'($urandom);
			if ($urandom_range(0, 9) == 0) r.pitch = corners[$urandom_range(0, 6)];
			send(r);
		end
		in_valid <= 0;
		while (quat_queue.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);

		$display("%0d attitudes sent (%0d directed corners), %0d quaternions checked",
			n_in, dir.size(), n_out);
		$display("mismatches: %0d, still pending: %0d", n_bad, quat_queue.size());
		if (n_bad == 0 && quat_queue.size() == 0)
			$display("** euler_to_quaternion: PASSED **");
		else
			$display("** euler_to_quaternion: FAILED **");
		$finish;
	end
endmodule
